// File: rtl/teleop_wheel_mix_packetizer_defines.svh
// Assertion macros for the teleop wheel mix packetizer.
// Used by modules that hold concurrent assertions; expects clk and arst_n in scope.
`ifndef TELEOP_WHEEL_MIX_PACKETIZER_DEFINES_SVH
`define TELEOP_WHEEL_MIX_PACKETIZER_DEFINES_SVH

// property must hold at every edge outside reset
`define TWMP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// property must never hold outside reset
`define TWMP_NEVER(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(prop)) else $error(msg);

`endif

// File: rtl/twmp_pkg.sv
// Package for the teleop wheel mix packetizer: packet layout constants, types, helpers.
// No dependencies.
package twmp_pkg;

	localparam int EMPTY_SLOTS = 4;
	localparam int SLOT_BYTES = 6;
	localparam int TOTAL_BYTES = 1 + SLOT_BYTES * EMPTY_SLOTS + SLOT_BYTES;
	localparam int LAST_SLOT_START = 1 + SLOT_BYTES * EMPTY_SLOTS;
	localparam int IDX_W = $clog2(TOTAL_BYTES);
	localparam int POS_W = $clog2(SLOT_BYTES);

	localparam logic [POS_W-1:0] POS_DRIB = POS_W'(4);
	localparam logic [POS_W-1:0] POS_KICK = POS_W'(5);

	localparam logic [7:0] AXIS_CENTER = 8'h80;
	localparam logic [7:0] AXIS_MAX_POS = 8'h7f;
	localparam logic [7:0] EMPTY_MARK = 8'h0f;

	typedef struct packed {
		logic [3:0] seq;
		logic [3:0] drib;
		logic [2:0] robot;
	} state_t;

	typedef struct packed {
		logic [7:0] header;
		logic [3:0][7:0] wheel;
		logic [7:0] drib_robot;
		logic [7:0] kick;
	} pkt_t;

	function automatic logic [7:0] clamp127(input logic signed [9:0] w);
		logic [7:0] r;
		if (w > 10'sd127) begin
			r = 8'h7f;
		end else if (w < -10'sd127) begin
			r = 8'h81;
		end else begin
			r = w[7:0];
		end
		return r;
	endfunction

endpackage

// File: rtl/twmp_mix.sv
// Wheel mixer: derives drive values, wheel speeds, dribble, robot and kick for one item.
// Depends on twmp_pkg.
module twmp_mix import twmp_pkg::*; (
	input  logic        device_ready,
	input  logic [7:0]  left_stick_x,
	input  logic [7:0]  left_stick_y,
	input  logic [7:0]  right_stick_x,
	input  logic [7:0]  right_stick_y,
	input  logic [15:0] button_bits,
	input  state_t      cur,
	output state_t      nxt,
	output pkt_t        pkt
);

	logic [7:0] lx, ly, rx, ry;
	logic [15:0] btn;
	logic [7:0] dx, dy, ds;
	logic signed [9:0] sx, sy, ss;
	logic [7:0] ly_off;

	always_comb begin
		lx = device_ready ? left_stick_x : AXIS_CENTER;
		ly = device_ready ? left_stick_y : AXIS_CENTER;
		rx = device_ready ? right_stick_x : AXIS_CENTER;
		ry = device_ready ? right_stick_y : AXIS_CENTER;
		btn = device_ready ? button_bits : 16'h0000;

		dx = rx - AXIS_CENTER;
		dy = AXIS_MAX_POS - ry;
		ds = AXIS_MAX_POS - lx;
		sx = {{2{dx[7]}}, dx};
		sy = {{2{dy[7]}}, dy};
		ss = {{2{ds[7]}}, ds};

		nxt.seq = cur.seq + 4'd1;

		ly_off = AXIS_MAX_POS - ly;
		nxt.drib = device_ready ? cur.drib : 4'd0;
		if (btn[8]) begin
			nxt.drib = ly[7] ? 4'd0 : ly_off[6:3];
		end

		nxt.robot = cur.robot;
		if (btn[13]) begin
			nxt.robot = 3'd0;
		end else if (btn[4]) begin
			nxt.robot = 3'd1;
		end else if (btn[5]) begin
			nxt.robot = 3'd2;
		end else if (btn[6]) begin
			nxt.robot = 3'd3;
		end else if (btn[7]) begin
			nxt.robot = 3'd4;
		end

		pkt.header = {nxt.seq, EMPTY_MARK[3:0]};
		pkt.wheel[0] = clamp127(-ss - sx + sy);
		pkt.wheel[1] = clamp127(-ss + sx + sy);
		pkt.wheel[2] = clamp127(-ss + sx - sy);
		pkt.wheel[3] = clamp127(-ss - sx - sy);
		pkt.drib_robot = {nxt.drib, 1'b0, nxt.robot};
		pkt.kick = (btn[11] | btn[9]) ? 8'hff : 8'h00;
	end

endmodule

// File: rtl/twmp_ser.sv
// Serializer: header, empty slots, robot slot; one byte per cycle unless stalled.
// Depends on twmp_pkg and teleop_wheel_mix_packetizer_defines.svh.
`include "teleop_wheel_mix_packetizer_defines.svh"

module twmp_ser import twmp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pkt_valid,
	input  pkt_t       pkt,
	output logic       pkt_take,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] packet_byte,
	output logic       last_byte
);

	pkt_t cur_q;
	logic busy_q;
	logic [IDX_W-1:0] idx_q;
	logic [POS_W-1:0] pos_q;
	logic out_acc;

	assign last_byte = idx_q == IDX_W'(TOTAL_BYTES - 1);
	assign out_valid = busy_q;
	assign out_acc = busy_q && out_ready;
	assign pkt_take = pkt_valid && (!busy_q || (out_acc && last_byte));

	always_comb begin
		if (idx_q == '0) begin
			packet_byte = cur_q.header;
		end else if (idx_q < IDX_W'(LAST_SLOT_START)) begin
			packet_byte = (pos_q == POS_DRIB) ? EMPTY_MARK : 8'h00;
		end else begin
			case (pos_q)
				POS_DRIB: packet_byte = cur_q.drib_robot;
				POS_KICK: packet_byte = cur_q.kick;
				default:  packet_byte = cur_q.wheel[pos_q[1:0]];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
			pos_q <= '0;
		end else if (pkt_take) begin
			busy_q <= 1'b1;
			idx_q <= '0;
			pos_q <= '0;
		end else if (out_acc) begin
			if (last_byte) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
				if (idx_q != '0) begin
					pos_q <= (pos_q == POS_W'(SLOT_BYTES - 1)) ? '0 : pos_q + POS_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_take) begin
			cur_q <= pkt;
		end
	end

	`TWMP_ASSERT(a_stay_busy, busy_q && out_ready && !last_byte |=> busy_q, "packet cut short")
	`TWMP_ASSERT(a_idx_step, busy_q && out_ready && !last_byte |=> idx_q == $past(idx_q) + IDX_W'(1), "byte index skipped")
	`TWMP_ASSERT(a_take_end, pkt_take && busy_q |-> out_ready && last_byte, "packet replaced mid-stream")
	`TWMP_NEVER(a_pos_range, busy_q && pos_q > POS_W'(SLOT_BYTES - 1), "slot position out of range")

endmodule

// File: rtl/teleop_wheel_mix_packetizer.sv
// An accepted item is registered in the pending packet register, then loaded
// into the serializer once free; the serializer then shows its first packet byte.
// Each item yields 31 bytes, one per cycle while out_ready is high. A one-packet
// input register takes the next item while the current packet streams out.
// Reset clears sequence, dribble and robot state and empties both packet stages.
// Top level: mixer, pending packet register and serializer. Depends on twmp_pkg.
module teleop_wheel_mix_packetizer import twmp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        device_ready,
	input  logic [7:0]  left_stick_x,
	input  logic [7:0]  left_stick_y,
	input  logic [7:0]  right_stick_x,
	input  logic [7:0]  right_stick_y,
	input  logic [15:0] button_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  packet_byte,
	output logic        last_byte
);

	state_t st_q;
	state_t st_nxt;
	pkt_t pkt_nxt;
	pkt_t pkt_s1;
	logic full_s1;
	logic take;
	logic in_acc;

	twmp_mix u_mix (
		.device_ready (device_ready),
		.left_stick_x (left_stick_x),
		.left_stick_y (left_stick_y),
		.right_stick_x(right_stick_x),
		.right_stick_y(right_stick_y),
		.button_bits  (button_bits),
		.cur          (st_q),
		.nxt          (st_nxt),
		.pkt          (pkt_nxt)
	);

	assign in_ready = !full_s1 || take;
	assign in_acc = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
			full_s1 <= 1'b0;
		end else if (in_acc) begin
			st_q <= st_nxt;
			full_s1 <= 1'b1;
		end else if (take) begin
			full_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pkt_s1 <= pkt_nxt;
		end
	end

	twmp_ser u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.pkt_valid  (full_s1),
		.pkt        (pkt_s1),
		.pkt_take   (take),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.packet_byte(packet_byte),
		.last_byte  (last_byte)
	);

endmodule

// File: sim/twmp_packet_checker.sv
// Button masks shared by the bench, and the packet checker for the teleop wheel mix packetizer.
// Checker predicts every 31-byte packet from the accepted stick item and compares byte by byte.
// Depends on twmp_pkg for the packet layout and axis constants.
package twmp_tb_pkg;

	localparam logic [15:0] BTN_ROBOT1  = 16'h0010;
	localparam logic [15:0] BTN_ROBOT2  = 16'h0020;
	localparam logic [15:0] BTN_ROBOT3  = 16'h0040;
	localparam logic [15:0] BTN_ROBOT4  = 16'h0080;
	localparam logic [15:0] BTN_DRIBBLE = 16'h0100;
	localparam logic [15:0] BTN_KICK6   = 16'h0200;
	localparam logic [15:0] BTN_KICK8   = 16'h0800;
	localparam logic [15:0] BTN_ROBOT0  = 16'h2000;
	localparam logic [15:0] BTN_UNUSED  = 16'hd40f;

endpackage

module twmp_packet_checker import twmp_pkg::*, twmp_tb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        device_ready,
	input  logic [7:0]  left_stick_x,
	input  logic [7:0]  left_stick_y,
	input  logic [7:0]  right_stick_x,
	input  logic [7:0]  right_stick_y,
	input  logic [15:0] button_bits,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  packet_byte,
	input  logic        last_byte,
	output int          error_count,
	output int          pending,
	output int          bytes_checked,
	output int          packets_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} pkt_byte_t;

	pkt_byte_t  expected_bytes[$];
	logic [3:0] pkt_seq = '0;
	logic [3:0] drib_level = '0;
	logic [2:0] robot_id = '0;
	int         mismatches = 0;

	assign error_count = mismatches;

	task automatic report(input string what, input int got, input int want);
		if (mismatches < 20) begin
			$display("[%0t] mismatch: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
		end
		mismatches++;
	endtask

	function automatic logic [7:0] wheel_speed_byte(input int w);
		int c;
		c = w;
		if (c > 127) begin
			c = 127;
		end else if (c < -127) begin
			c = -127;
		end
		return 8'(c);
	endfunction

	task automatic predict_packet(input logic rdy, input logic [7:0] lx, input logic [7:0] ly,
			input logic [7:0] rx, input logic [7:0] ry, input logic [15:0] btn);
		logic signed [7:0] dx;
		logic signed [7:0] dy;
		logic signed [7:0] ds;
		logic [7:0]        kick;
		int                sx;
		int                sy;
		int                ss;
		if (!rdy) begin
			lx = AXIS_CENTER;
			ly = AXIS_CENTER;
			rx = AXIS_CENTER;
			ry = AXIS_CENTER;
			btn = '0;
			drib_level = '0;
		end
		dx = rx - AXIS_CENTER;
		dy = AXIS_MAX_POS - ry;
		ds = AXIS_MAX_POS - lx;
		sx = int'(dx);
		sy = int'(dy);
		ss = int'(ds);
		kick = ((btn & (BTN_KICK6 | BTN_KICK8)) != '0) ? 8'hff : 8'h00;
		if ((btn & BTN_DRIBBLE) != '0) begin
			drib_level = (ly <= AXIS_MAX_POS) ? 4'((AXIS_MAX_POS - ly) >> 3) : 4'd0;
		end
		if ((btn & BTN_ROBOT0) != '0) begin
			robot_id = 3'd0;
		end else if ((btn & BTN_ROBOT1) != '0) begin
			robot_id = 3'd1;
		end else if ((btn & BTN_ROBOT2) != '0) begin
			robot_id = 3'd2;
		end else if ((btn & BTN_ROBOT3) != '0) begin
			robot_id = 3'd3;
		end else if ((btn & BTN_ROBOT4) != '0) begin
			robot_id = 3'd4;
		end
		pkt_seq = pkt_seq + 4'd1;
		expected_bytes.push_back('{{pkt_seq, 4'hf}, 1'b0});
		for (int s = 0; s < EMPTY_SLOTS; s++) begin
			for (int b = 0; b < SLOT_BYTES; b++) begin
				expected_bytes.push_back('{(b == int'(POS_DRIB)) ? EMPTY_MARK : 8'h00, 1'b0});
			end
		end
		expected_bytes.push_back('{wheel_speed_byte(-ss - sx + sy), 1'b0});
		expected_bytes.push_back('{wheel_speed_byte(-ss + sx + sy), 1'b0});
		expected_bytes.push_back('{wheel_speed_byte(-ss + sx - sy), 1'b0});
		expected_bytes.push_back('{wheel_speed_byte(-ss - sx - sy), 1'b0});
		expected_bytes.push_back('{{drib_level, 1'b0, robot_id}, 1'b0});
		expected_bytes.push_back('{kick, 1'b1});
	endtask

	always @(posedge clk or negedge arst_n) begin
		pkt_byte_t want;
		if (!arst_n) begin
			expected_bytes.delete();
			pkt_seq = '0;
			drib_level = '0;
			robot_id = '0;
			pending <= 0;
			bytes_checked <= 0;
			packets_checked <= 0;
		end else begin
			if (out_valid && out_ready) begin
				bytes_checked <= bytes_checked + 1;
				if (last_byte) begin
					packets_checked <= packets_checked + 1;
				end
				if (expected_bytes.size() == 0) begin
					report("byte with nothing pending", packet_byte, 0);
				end else begin
					want = expected_bytes.pop_front();
					if (packet_byte !== want.data) begin
						report("packet_byte", packet_byte, want.data);
					end
					if (last_byte !== want.last) begin
						report("last_byte", last_byte, want.last);
					end
				end
			end
			if (in_valid && in_ready) begin
				predict_packet(device_ready, left_stick_x, left_stick_y, right_stick_x,
					right_stick_y, button_bits);
			end
			pending <= expected_bytes.size();
		end
	end

endmodule

// File: sim/tb_teleop_wheel_mix_packetizer.sv
// Top of the bench for the teleop wheel mix packetizer: clock, reset, stick items and verdict.
// Directed corner items, then random items with bursts of idling on both channels.
// Depends on twmp_pkg, twmp_tb_pkg and twmp_packet_checker.
module tb_teleop_wheel_mix_packetizer import twmp_pkg::*, twmp_tb_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 85;
	localparam int CALM_ITEMS = 15;
	localparam int CYCLE_LIMIT = 300000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        device_ready = 1'b0;
	logic [7:0]  left_stick_x = '0;
	logic [7:0]  left_stick_y = '0;
	logic [7:0]  right_stick_x = '0;
	logic [7:0]  right_stick_y = '0;
	logic [15:0] button_bits = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  packet_byte;
	logic        last_byte;

	int error_count;
	int pending;
	int bytes_checked;
	int packets_checked;
	int cycles = 0;
	int items_sent = 0;
	int items_not_ready = 0;
	int in_gap_pct = 30;
	int out_stall_pct = 10;

	always #2 clk = ~clk;

	teleop_wheel_mix_packetizer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.device_ready (device_ready),
		.left_stick_x (left_stick_x),
		.left_stick_y (left_stick_y),
		.right_stick_x(right_stick_x),
		.right_stick_y(right_stick_y),
		.button_bits  (button_bits),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.packet_byte  (packet_byte),
		.last_byte    (last_byte)
	);

	twmp_packet_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.device_ready   (device_ready),
		.left_stick_x   (left_stick_x),
		.left_stick_y   (left_stick_y),
		.right_stick_x  (right_stick_x),
		.right_stick_y  (right_stick_y),
		.button_bits    (button_bits),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.packet_byte    (packet_byte),
		.last_byte      (last_byte),
		.error_count    (error_count),
		.pending        (pending),
		.bytes_checked  (bytes_checked),
		.packets_checked(packets_checked)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d bytes still pending", cycles, pending);
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_stall_pct > 0 && $urandom_range(0, 99) < out_stall_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	task automatic send_item(input logic rdy, input logic [7:0] lx, input logic [7:0] ly,
			input logic [7:0] rx, input logic [7:0] ry, input logic [15:0] btn);
		device_ready <= rdy;
		left_stick_x <= lx;
		left_stick_y <= ly;
		right_stick_x <= rx;
		right_stick_y <= ry;
		button_bits <= btn;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
		if (!rdy) begin
			items_not_ready++;
		end
		if (in_gap_pct > 0 && $urandom_range(0, 99) < in_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	function automatic logic [7:0] pick_axis();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hff;
			2: return AXIS_CENTER;
			3: return AXIS_MAX_POS;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_buttons();
		case ($urandom_range(0, 3))
			0: return 16'($urandom);
			1: return 16'($urandom & $urandom) | BTN_DRIBBLE;
			default: return 16'($urandom & $urandom & $urandom);
		endcase
	endfunction

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// axis extremes and mixer saturation
		send_item(1'b1, AXIS_CENTER, AXIS_CENTER, AXIS_CENTER, AXIS_CENTER, '0);
		send_item(1'b1, 8'h00, 8'h00, 8'h00, 8'h00, '0);
		send_item(1'b1, 8'hff, 8'hff, 8'hff, 8'hff, '0);
		send_item(1'b1, 8'h00, AXIS_CENTER, AXIS_CENTER, AXIS_CENTER, '0);
		send_item(1'b1, 8'hff, AXIS_CENTER, 8'h00, 8'hff, '0);
		send_item(1'b1, AXIS_MAX_POS, AXIS_CENTER, 8'hff, 8'h00, '0);
		// dribble latch, release, then cleared by a missing device
		send_item(1'b1, AXIS_CENTER, 8'h00, AXIS_CENTER, AXIS_CENTER, BTN_DRIBBLE);
		send_item(1'b1, AXIS_CENTER, 8'hff, AXIS_CENTER, AXIS_CENTER, '0);
		send_item(1'b0, 8'h12, 8'h00, 8'hff, 8'h00, 16'hffff);
		send_item(1'b1, AXIS_CENTER, 8'h40, AXIS_CENTER, AXIS_CENTER, BTN_DRIBBLE);
		send_item(1'b1, AXIS_CENTER, AXIS_CENTER, AXIS_CENTER, AXIS_CENTER, BTN_DRIBBLE);
		send_item(1'b1, AXIS_CENTER, 8'h38, AXIS_CENTER, AXIS_CENTER, BTN_DRIBBLE);
		send_item(1'b1, AXIS_CENTER, AXIS_MAX_POS, AXIS_CENTER, AXIS_CENTER, BTN_DRIBBLE);
		send_item(1'b1, AXIS_CENTER, 8'hff, AXIS_CENTER, AXIS_CENTER, BTN_DRIBBLE);
		// robot priority and hold
		send_item(1'b1, AXIS_CENTER, AXIS_CENTER, AXIS_CENTER, AXIS_CENTER, BTN_ROBOT4);
		send_item(1'b1, AXIS_CENTER, AXIS_CENTER, AXIS_CENTER, AXIS_CENTER, BTN_ROBOT3);
		send_item(1'b1, AXIS_CENTER, AXIS_CENTER, AXIS_CENTER, AXIS_CENTER, BTN_ROBOT2);
		send_item(1'b1, AXIS_CENTER, AXIS_CENTER, AXIS_CENTER, AXIS_CENTER,
			BTN_ROBOT1 | BTN_ROBOT4);
		send_item(1'b1, AXIS_CENTER, AXIS_CENTER, AXIS_CENTER, AXIS_CENTER,
			BTN_ROBOT3 | BTN_ROBOT4);
		send_item(1'b1, AXIS_CENTER, AXIS_CENTER, AXIS_CENTER, AXIS_CENTER, '0);
		send_item(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, BTN_ROBOT1);
		send_item(1'b1, AXIS_CENTER, AXIS_CENTER, AXIS_CENTER, AXIS_CENTER,
			BTN_ROBOT0 | BTN_ROBOT1 | BTN_ROBOT2);
		// kick sources and ignored buttons
		send_item(1'b1, 8'h01, 8'hfe, 8'h7f, 8'h81, BTN_KICK6);
		send_item(1'b1, 8'h81, 8'h01, 8'h80, 8'h7e, BTN_KICK8 | BTN_UNUSED);
		send_item(1'b1, 8'hfe, 8'h7e, 8'h01, 8'hfe, BTN_KICK6 | BTN_KICK8);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i >= RANDOM_ITEMS - CALM_ITEMS) begin
				in_gap_pct = 0;
				out_stall_pct = 0;
			end else if (i % 16 == 0) begin
				case ($urandom_range(0, 2))
					0: in_gap_pct = 0;
					1: in_gap_pct = 30;
					default: in_gap_pct = 70;
				endcase
				case ($urandom_range(0, 2))
					0: out_stall_pct = 0;
					1: out_stall_pct = 5;
					default: out_stall_pct = 15;
				endcase
			end
			send_item($urandom_range(0, 9) != 0, pick_axis(), pick_axis(), pick_axis(),
				pick_axis(), pick_buttons());
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("drove %0d stick items (%0d with no device), %0d packets / %0d bytes checked",
			items_sent, items_not_ready, packets_checked, bytes_checked);
		$display("idling on both channels, %0d mismatches in %0d cycles", error_count, cycles);
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
